/* hw/rtl/fbcb_pkg.sv */
// Package for the circle blend raster core: payload structs, command codes,
// sequencer states and the per-lane blend function. No dependencies.
`default_nettype none
package fbcb_pkg;

   typedef enum logic [2:0] {
      FUNC_SET   = 3'd0,
      FUNC_BLEND = 3'd1,
      FUNC_READ  = 3'd2,
      FUNC_DISC  = 3'd3,
      FUNC_RING  = 3'd4
   } func_type;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  x_coord;
      logic [7:0]  y_coord;
      logic [7:0]  radius;
      logic [7:0]  border;
      logic [31:0] color;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic        coord_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_WALK,
      ST_WALK_WR,
      ST_DONE
   } state_type;

   // Exact floor(n/255) for n < 65280: q = (n + 1 + (n >> 8)) >> 8.
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] s;
      s = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
      return s[15:8];
   endfunction

   function automatic logic [31:0] blend(input logic [31:0] back,
                                         input logic [31:0] fore);
      logic [7:0]  a;
      logic [15:0] n;
      logic [31:0] res;
      a = fore[31:24];
      res = '0;
      for (int l = 0; l < 4; l++) begin
         n = 16'(fore[l*8 +: 8]) * 16'(a) + 16'(back[l*8 +: 8]) * 16'(8'd255 - a);
         res[l*8 +: 8] = div255(n);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/fbcb_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module fbcb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/framebuffer_circle_blend_raster_core.sv */
// Circle blend raster core: framebuffer with set/blend/read pixel and disc/ring fill.
// A set/read/blend command goes from accept through the pixel read and pixel write
// states to the done state, which registers rsp_valid; an off-canvas pixel or a spare
// code goes straight to the done state. A disc or ring walks every pixel of its clipped
// box and adds a blend write for each covered pixel. The next request can be taken in the
// cycle in which rsp_valid rises; a stalled response holds only the finished command, and
// the next command runs up to its done state and waits there. After reset a clearing pass
// zeroes the store; no request is accepted meanwhile. Depends on fbcb_pkg and fbcb_ram.
`default_nettype none
module framebuffer_circle_blend_raster_core
   import fbcb_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_data
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = 13;

   state_type   state_ff, state_in;
   logic [8:0]  width_ff, width_in, height_ff, height_in;
   req_type     cmd_ff, cmd_in;
   logic [AW:0] clr_ff, clr_in;
   logic [CW-1:0] x_ff, x_in, y_ff, y_in, x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [AW-1:0] addr_ff, addr_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [31:0]   ram_wd, ram_rd;

   fbcb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   logic [CW-1:0] ew, eh;
   always_comb begin
      ew = ({4'd0, width_ff} > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : {4'd0, width_ff};
      eh = ({4'd0, height_ff} > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : {4'd0, height_ff};
   end

   // Distance test for the current walk position.
   logic signed [CW:0] dx, dy, inner;
   logic [31:0] d2, out2, in2;
   logic        hit;
   always_comb begin
      dx    = $signed({1'b0, x_ff}) - $signed({6'd0, cmd_ff.x_coord});
      dy    = $signed({1'b0, y_ff}) - $signed({6'd0, cmd_ff.y_coord});
      inner = $signed({6'd0, cmd_ff.radius}) - $signed({6'd0, cmd_ff.border});
      d2    = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
      out2  = 32'(cmd_ff.radius) * 32'(cmd_ff.radius);
      in2   = 32'(inner) * 32'(inner);
      hit   = (d2 <= out2) && ((cmd_ff.func != FUNC_RING) || (d2 >= in2));
   end

   logic [AW-1:0] lin;
   always_comb lin = AW'(x_ff) + AW'(y_ff) * AW'(ew);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      x0_ff   <= x0_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   logic signed [CW:0] lo_x, lo_y, hi_x, hi_y;

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      x_in = x_ff; y_in = y_ff; x0_in = x0_ff; x1_in = x1_ff; y1_in = y1_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_addr     = addr_ff;
      ram_we       = 1'b0;
      ram_wd       = '0;
      req_stall    = 1'b1;
      csr_ready    = 1'b1;
      lo_x = $signed({6'd0, req_data.x_coord}) - $signed({6'd0, req_data.radius});
      lo_y = $signed({6'd0, req_data.y_coord}) - $signed({6'd0, req_data.radius});
      hi_x = $signed({6'd0, req_data.x_coord}) + $signed({6'd0, req_data.radius});
      hi_y = $signed({6'd0, req_data.y_coord}) + $signed({6'd0, req_data.radius});

      if (csr_valid) begin
         if (csr_index == CSR_WIDTH) width_in = csr_data;
         else                        height_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_addr = clr_ff[AW-1:0];
            ram_we   = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // A waiting response sits in its own register, so a new command can start.
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in = req_data;
               res_in = '0;
               x_in   = CW'(req_data.x_coord);
               y_in   = CW'(req_data.y_coord);
               if (req_data.func == FUNC_SET || req_data.func == FUNC_BLEND ||
                   req_data.func == FUNC_READ) begin
                  if (x_in >= ew || y_in >= eh) begin
                     res_in.coord_error = 1'b1;
                     state_in = ST_DONE;
                  end else state_in = ST_PIX_RD;
               end else if (req_data.func == FUNC_DISC || req_data.func == FUNC_RING) begin
                  x0_in = lo_x < 0 ? '0 : CW'(lo_x);
                  y_in  = lo_y < 0 ? '0 : CW'(lo_y);
                  x_in  = x0_in;
                  x1_in = (hi_x > $signed({1'b0, ew})) ? ew : CW'(hi_x);
                  y1_in = (hi_y > $signed({1'b0, eh})) ? eh : CW'(hi_y);
                  state_in = ST_WALK;
               end else state_in = ST_DONE;
            end
         end
         ST_PIX_RD: begin
            addr_in  = lin;
            ram_addr = lin;
            state_in = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            if (cmd_ff.func == FUNC_SET) begin
               ram_we = 1'b1; ram_wd = cmd_ff.color;
            end else if (cmd_ff.func == FUNC_BLEND) begin
               ram_we = 1'b1; ram_wd = blend(ram_rd, cmd_ff.color);
            end else res_in.pixel_value = ram_rd;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            // Row-major walk: blend order is irrelevant since pixels are distinct.
            if (y_ff >= y1_ff || x0_ff >= x1_ff) state_in = ST_DONE;
            else begin
               addr_in  = lin;
               ram_addr = lin;
               if (hit) state_in = ST_WALK_WR;
               if (x_ff + 1'b1 >= x1_ff) begin
                  x_in = x0_ff; y_in = y_ff + 1'b1;
               end else x_in = x_ff + 1'b1;
            end
         end
         ST_WALK_WR: begin
            ram_we   = 1'b1;
            ram_wd   = blend(ram_rd, cmd_ff.color);
            state_in = ST_WALK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall) else $error("accept during clear");
   a_wr_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_WR) |-> ($past(state_ff) == ST_WALK)) else $error("write w/o read");
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.coord_error && rsp_data.pixel_value != 0))
      else $error("error with value");
`endif
endmodule
`default_nettype wire
